@@ hw/rtl/pdsc_pkg.sv @@
package pdsc_pkg;

	localparam int BASES_PER_CHUNK = 28;
	localparam int LENGTH_BITS     = 32;

	typedef enum logic [2:0] {
		OUT_FIRST_LESS    = 3'd0,
		OUT_FIRST_PREFIX  = 3'd1,
		OUT_EQUAL         = 3'd2,
		OUT_SECOND_PREFIX = 3'd3,
		OUT_SECOND_LESS   = 3'd4
	} outcome_t;

	typedef struct packed {
		logic [63:0] left_word;
		logic [1:0]  left_offset;
		logic        left_revcomp;
		logic [63:0] right_word;
		logic [1:0]  right_offset;
		logic        right_revcomp;
		logic [4:0]  valid_bases;
		logic [31:0] left_length;
		logic [31:0] right_length;
		logic        last_chunk;
	} in_item_t;

	typedef struct packed {
		outcome_t    outcome;
		logic [31:0] prefix_length;
	} out_item_t;

	// base lane of an aligned chunk, taken straight from the raw word
	// forward: group offset+lane from the top; reverse complement: inverted
	// group 28+offset-lane from the top
	function automatic logic [1:0] pick_base(input logic [63:0] word, input logic [1:0] off,
		input logic rc, input logic [4:0] lane);
		logic [31:0][1:0] grp;
		logic [4:0]       fwd;
		logic [4:0]       rev;
		grp = word;
		fwd = 5'd31 - lane - {3'd0, off};
		rev = 5'd3 + lane - {3'd0, off};
		return rc ? ~grp[rev] : grp[fwd];
	endfunction

endpackage

@@ hw/rtl/pdsc_lane.sv @@
module pdsc_lane import pdsc_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic [63:0] left_word,
	input  logic [1:0]  left_offset,
	input  logic        left_revcomp,
	input  logic [63:0] right_word,
	input  logic [1:0]  right_offset,
	input  logic        right_revcomp,
	output logic        eq,
	output logic        lt
);

	logic [1:0] x;
	logic [1:0] y;

	always_comb begin
		x  = pick_base(left_word, left_offset, left_revcomp, 5'(IDX));
		y  = pick_base(right_word, right_offset, right_revcomp, 5'(IDX));
		eq = (x == y);
		lt = (x < y);
	end

endmodule

@@ hw/rtl/pdsc_merge.sv @@
module pdsc_merge import pdsc_pkg::*; #(
	parameter int BASES_PER_CHUNK = pdsc_pkg::BASES_PER_CHUNK,
	parameter int LENGTH_BITS     = pdsc_pkg::LENGTH_BITS,
	localparam int NW = $clog2(BASES_PER_CHUNK + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [BASES_PER_CHUNK-1:0] eq_vec,
	input  logic [BASES_PER_CHUNK-1:0] lt_vec,
	input  logic [NW-1:0]              n,
	input  logic                       go,
	input  logic                       last,
	output logic                       decided_next,
	output logic                       less_next,
	output logic [LENGTH_BITS-1:0]     count_next
);

	logic                       decided_q;
	logic                       less_q;
	logic [LENGTH_BITS-1:0]     count_q;
	logic [BASES_PER_CHUNK-1:0] mism;
	logic [BASES_PER_CHUNK-1:0] first;
	logic [NW-1:0]              k;
	logic [NW-1:0]              add;
	logic                       found;
	logic                       less_here;
	logic [LENGTH_BITS:0]       sum;

	always_comb begin
		for (int i = 0; i < BASES_PER_CHUNK; i++) begin
			mism[i] = !eq_vec[i] && (NW'(i) < n);
		end
		// isolate the earliest mismatching base
		first     = mism & (~mism + (BASES_PER_CHUNK)'(1));
		found     = |mism;
		less_here = |(first & lt_vec);
		k         = '0;
		for (int i = 0; i < BASES_PER_CHUNK; i++) begin
			k = k | (first[i] ? NW'(i) : '0);
		end
		add = found ? k : n;
		sum = {1'b0, count_q} + (LENGTH_BITS + 1)'(add);
		if (decided_q) begin
			decided_next = 1'b1;
			less_next    = less_q;
			count_next   = count_q;
		end else begin
			decided_next = found;
			less_next    = less_here;
			count_next   = sum[LENGTH_BITS] ? '1 : sum[LENGTH_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decided_q <= 1'b0;
			less_q    <= 1'b0;
			count_q   <= '0;
		end else if (go) begin
			if (last) begin
				decided_q <= 1'b0;
				less_q    <= 1'b0;
				count_q   <= '0;
			end else begin
				decided_q <= decided_next;
				less_q    <= less_next;
				count_q   <= count_next;
			end
		end
	end

endmodule

@@ hw/rtl/pdsc_result.sv @@
module pdsc_result import pdsc_pkg::*; #(
	parameter int LENGTH_BITS = pdsc_pkg::LENGTH_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid,
	input  logic                   decided,
	input  logic                   less,
	input  logic [LENGTH_BITS-1:0] count,
	input  logic [LENGTH_BITS-1:0] minlen,
	input  outcome_t               len_code,
	input  logic                   len_zero,
	output logic                   take,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_data
);

	logic                    out_valid_q;
	out_item_t               out_data_q;
	outcome_t                res_code;
	logic [LENGTH_BITS-1:0]  pfx;
	logic [LENGTH_BITS+31:0] pfx_wide;
	logic                    below;

	assign take = !out_valid_q || out_ready;

	always_comb begin
		below = (count < minlen);
		if (len_zero) begin
			res_code = len_code;
			pfx      = '0;
		end else if (decided && below) begin
			res_code = less ? OUT_FIRST_LESS : OUT_SECOND_LESS;
			pfx      = count;
		end else begin
			res_code = len_code;
			pfx      = below ? count : minlen;
		end
		pfx_wide = {32'd0, pfx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && valid) begin
			out_data_q.outcome       <= res_code;
			out_data_q.prefix_length <= pfx_wide[31:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ hw/rtl/packed_dna_sequence_compare_top.sv @@
// Compares two 2-bit packed DNA sequences chunk by chunk, each side read
// forward or reverse complemented from its own offset, and on the item
// marked last_chunk gives one result: the ordering outcome and the length of
// the shared prefix. One item is accepted every clock while the output side
// keeps up; the result for a last item goes from the lane compares,
// registered on acceptance, through the merge into the running count and
// then the result register before it shows on out_valid. Items without
// last_chunk give no result and never wait for the output side.
module packed_dna_sequence_compare_top import pdsc_pkg::*; #(
	parameter int BASES_PER_CHUNK = pdsc_pkg::BASES_PER_CHUNK,
	parameter int LENGTH_BITS     = pdsc_pkg::LENGTH_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int NW = $clog2(BASES_PER_CHUNK + 1);

	logic [BASES_PER_CHUNK-1:0] eq_vec;
	logic [BASES_PER_CHUNK-1:0] lt_vec;
	logic [NW-1:0]              n_clamp;
	logic [LENGTH_BITS+31:0]    ll_wide;
	logic [LENGTH_BITS+31:0]    rl_wide;
	logic [LENGTH_BITS-1:0]     ll;
	logic [LENGTH_BITS-1:0]     rl;
	outcome_t                   code_in;

	logic                       valid_s1;
	logic [BASES_PER_CHUNK-1:0] eq_s1;
	logic [BASES_PER_CHUNK-1:0] lt_s1;
	logic [NW-1:0]              n_s1;
	logic                       last_s1;
	logic [LENGTH_BITS-1:0]     minlen_s1;
	outcome_t                   code_s1;
	logic                       zero_s1;

	logic                       valid_s2;
	logic                       decided_s2;
	logic                       less_s2;
	logic [LENGTH_BITS-1:0]     count_s2;
	logic [LENGTH_BITS-1:0]     minlen_s2;
	outcome_t                   code_s2;
	logic                       zero_s2;

	logic                       decided_next;
	logic                       less_next;
	logic [LENGTH_BITS-1:0]     count_next;
	logic                       take_out;
	logic                       adv2;
	logic                       s1_go;
	logic                       in_fire;
	logic                       s2_load;

	for (genvar i = 0; i < BASES_PER_CHUNK; i++) begin : g_lane
		pdsc_lane #(
			.IDX(i)
		) u_lane (
			.left_word    (in_data.left_word),
			.left_offset  (in_data.left_offset),
			.left_revcomp (in_data.left_revcomp),
			.right_word   (in_data.right_word),
			.right_offset (in_data.right_offset),
			.right_revcomp(in_data.right_revcomp),
			.eq           (eq_vec[i]),
			.lt           (lt_vec[i])
		);
	end

	always_comb begin
		n_clamp = (in_data.valid_bases > 5'(BASES_PER_CHUNK)) ?
			NW'(BASES_PER_CHUNK) : NW'(in_data.valid_bases);
		ll_wide = {(LENGTH_BITS)'(0), in_data.left_length};
		rl_wide = {(LENGTH_BITS)'(0), in_data.right_length};
		ll      = ll_wide[LENGTH_BITS-1:0];
		rl      = rl_wide[LENGTH_BITS-1:0];
		if (ll == rl) begin
			code_in = OUT_EQUAL;
		end else if (ll < rl) begin
			code_in = OUT_FIRST_PREFIX;
		end else begin
			code_in = OUT_SECOND_PREFIX;
		end
	end

	// handshake: non-last items retire from s1 without needing s2
	assign adv2     = !valid_s2 || take_out;
	assign s1_go    = valid_s1 && (!last_s1 || adv2);
	assign in_ready = !valid_s1 || s1_go;
	assign in_fire  = in_valid && in_ready;
	assign s2_load  = s1_go && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s2_load) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			eq_s1     <= eq_vec;
			lt_s1     <= lt_vec;
			n_s1      <= n_clamp;
			last_s1   <= in_data.last_chunk;
			minlen_s1 <= (ll < rl) ? ll : rl;
			code_s1   <= code_in;
			zero_s1   <= (ll == '0) || (rl == '0);
		end
		if (s2_load) begin
			decided_s2 <= decided_next;
			less_s2    <= less_next;
			count_s2   <= count_next;
			minlen_s2  <= minlen_s1;
			code_s2    <= code_s1;
			zero_s2    <= zero_s1;
		end
	end

	pdsc_merge #(
		.BASES_PER_CHUNK(BASES_PER_CHUNK),
		.LENGTH_BITS    (LENGTH_BITS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.eq_vec      (eq_s1),
		.lt_vec      (lt_s1),
		.n           (n_s1),
		.go          (s1_go),
		.last        (last_s1),
		.decided_next(decided_next),
		.less_next   (less_next),
		.count_next  (count_next)
	);

	pdsc_result #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s2),
		.decided  (decided_s2),
		.less     (less_s2),
		.count    (count_s2),
		.minlen   (minlen_s2),
		.len_code (code_s2),
		.len_zero (zero_s2),
		.take     (take_out),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && take_out |=> out_valid)
		else $error("finished comparison did not reach the output register");

	a_ready_only_blocked_by_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && last_s1 && valid_s2)
		else $error("input stalled with no item waiting");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !take_out |=> valid_s2 && $stable(count_s2) && $stable(code_s2))
		else $error("stalled result lost or changed");

endmodule
